>>> rtl/mhpf_pkg.sv
// shared types, constants and helpers of the frame header parser and filter
package mhpf_pkg;

  localparam logic [15:0] FC_FIXED_MASK  = 16'hf047;
  localparam logic [15:0] FC_FIXED_VALUE = 16'hc041;
  localparam logic [15:0] FC_CLEAR_MASK  = 16'h0198;
  localparam logic [15:0] FC_MODE_MASK   = 16'h0c00;
  localparam logic [15:0] FC_MODE_SHORT  = 16'h0800;

  localparam int unsigned IDX_W = 5;
  localparam logic [IDX_W-1:0] IDX_MAX       = 5'd31;
  localparam logic [IDX_W-1:0] IDX_CW_LO     = 5'd0;
  localparam logic [IDX_W-1:0] IDX_CW_HI     = 5'd1;
  localparam logic [IDX_W-1:0] IDX_SEQ       = 5'd2;
  localparam logic [IDX_W-1:0] IDX_PAN_LO    = 5'd3;
  localparam logic [IDX_W-1:0] IDX_PAN_HI    = 5'd4;
  localparam logic [IDX_W-1:0] IDX_DEST      = 5'd5;
  localparam logic [IDX_W-1:0] IDX_SHORT_END = 5'd6;
  localparam logic [IDX_W-1:0] SRC_OFF_SHORT = 5'd7;
  localparam logic [IDX_W-1:0] SRC_OFF_EXT   = 5'd13;
  localparam logic [IDX_W-1:0] HDR_SHORT     = 5'd15;
  localparam logic [IDX_W-1:0] HDR_EXT       = 5'd21;
  localparam logic [IDX_W-1:0] IDX_MIN_LAST  = 5'd4;

  localparam logic [15:0] SHORT_DEST_MAX = 16'd2;
  localparam logic [15:0] SHORT_DEST_ONE = 16'd1;
  localparam logic [15:0] SHORT_DEST_TWO = 16'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_TRUNC = 2'd1,
    STATUS_ADDR  = 2'd2,
    STATUS_DEST  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   payload_byte;
    status_e      status;
    logic [15:0]  frame_ctrl;
    logic [7:0]   sequence_number;
    logic [15:0]  dest_pan_id;
    logic         destination_extended;
    logic [63:0]  destination_address;
    logic [63:0]  source_address;
    logic         accepted;
    logic         final_result;
  } result_t;

  typedef struct packed {
    logic    pay_vld;
    logic    sum_vld;
    result_t pay;
    result_t sum;
  } push_t;

  function automatic logic control_ok(input logic [15:0] cw);
    return ((cw & FC_FIXED_MASK) == FC_FIXED_VALUE) &&
           ((cw & FC_CLEAR_MASK) == 16'h0000) &&
           ((cw & FC_MODE_SHORT) != 16'h0000);
  endfunction

endpackage

>>> rtl/mhpf_parse.sv
// input register, header field capture and result forming
module mhpf_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_end_i,
  input  logic [63:0]          node_eui_i,
  input  logic                 space_ok_i,
  output mhpf_pkg::push_t      push_o
);

  logic                       in_vld_q;
  logic [7:0]                 in_byte_q;
  logic                       in_last_q;
  logic                       adv;

  logic [mhpf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [15:0]                cw_q, cw_d;
  logic [7:0]                 seq_q, seq_d;
  logic [15:0]                pan_q, pan_d;
  logic [63:0]                dest_q, dest_d;
  logic [63:0]                src_q, src_d;
  logic                       cbad_q, cbad_d;
  logic                       sbad_q, sbad_d;

  assign in_stall_o = in_vld_q && !space_ok_i;
  assign adv        = in_vld_q && space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= frame_end_i;
    end
  end

  always_comb begin
    logic                       ext;
    logic [mhpf_pkg::IDX_W-1:0] hdr;
    logic [mhpf_pkg::IDX_W-1:0] src_off;
    logic [mhpf_pkg::IDX_W-1:0] doff;
    logic [mhpf_pkg::IDX_W-1:0] soff;
    logic                       in_dest;
    logic                       in_src;
    mhpf_pkg::status_e          st;
    logic                       acc;

    ext     = (cw_q & mhpf_pkg::FC_MODE_MASK) == mhpf_pkg::FC_MODE_MASK;
    hdr     = ext ? mhpf_pkg::HDR_EXT : mhpf_pkg::HDR_SHORT;
    src_off = ext ? mhpf_pkg::SRC_OFF_EXT : mhpf_pkg::SRC_OFF_SHORT;
    doff    = idx_q - mhpf_pkg::IDX_DEST;
    soff    = idx_q - src_off;
    in_dest = (idx_q >= mhpf_pkg::IDX_DEST) && (idx_q < src_off);
    in_src  = (idx_q >= src_off) && (idx_q < hdr);

    cw_d   = cw_q;
    seq_d  = seq_q;
    pan_d  = pan_q;
    dest_d = dest_q;
    src_d  = src_q;
    cbad_d = cbad_q;
    sbad_d = sbad_q;
    push_o = '0;

    if (idx_q == mhpf_pkg::IDX_CW_LO) begin
      cw_d = {8'h00, in_byte_q};
    end else if (idx_q == mhpf_pkg::IDX_CW_HI) begin
      cw_d   = cw_q | {in_byte_q, 8'h00};
      cbad_d = !mhpf_pkg::control_ok(cw_d);
    end else if (idx_q == mhpf_pkg::IDX_SEQ) begin
      seq_d = in_byte_q;
    end else if (idx_q == mhpf_pkg::IDX_PAN_LO) begin
      pan_d = {8'h00, in_byte_q};
    end else if (idx_q == mhpf_pkg::IDX_PAN_HI) begin
      pan_d = pan_q | {in_byte_q, 8'h00};
    end else if (in_dest) begin
      for (int k = 0; k < 8; k++) begin
        if (doff[2:0] == 3'(k)) begin
          dest_d[8*k +: 8] = dest_q[8*k +: 8] | in_byte_q;
        end
      end
      if (!ext && idx_q == mhpf_pkg::IDX_SHORT_END) begin
        sbad_d = dest_d[15:0] > mhpf_pkg::SHORT_DEST_MAX;
      end
    end else if (in_src) begin
      for (int k = 0; k < 8; k++) begin
        if (soff[2:0] == 3'(k)) begin
          src_d[8*k +: 8] = src_q[8*k +: 8] | in_byte_q;
        end
      end
    end else if (!cbad_q && !sbad_q) begin
      push_o.pay_vld          = adv;
      push_o.pay.kind         = mhpf_pkg::KIND_PAYLOAD;
      push_o.pay.payload_byte = in_byte_q;
      push_o.pay.final_result = !in_last_q;
    end

    if (idx_q < mhpf_pkg::IDX_MIN_LAST) begin
      st = mhpf_pkg::STATUS_TRUNC;
    end else if (cbad_d) begin
      st = mhpf_pkg::STATUS_ADDR;
    end else if (idx_q < hdr - 5'd1) begin
      st = mhpf_pkg::STATUS_TRUNC;
    end else if (!ext && sbad_d) begin
      st = mhpf_pkg::STATUS_DEST;
    end else begin
      st = mhpf_pkg::STATUS_OK;
    end

    if (ext) begin
      acc = dest_d == node_eui_i;
    end else begin
      acc = (dest_d[15:0] == mhpf_pkg::SHORT_DEST_ONE) ||
            (dest_d[15:0] == mhpf_pkg::SHORT_DEST_TWO);
    end

    push_o.sum_vld                  = adv && in_last_q;
    push_o.sum.kind                 = mhpf_pkg::KIND_SUMMARY;
    push_o.sum.status               = st;
    push_o.sum.frame_ctrl           = cw_d;
    push_o.sum.sequence_number      = seq_d;
    push_o.sum.dest_pan_id          = pan_d;
    push_o.sum.destination_extended = (st == mhpf_pkg::STATUS_OK) && ext;
    push_o.sum.destination_address  = dest_d;
    push_o.sum.source_address       = src_d;
    push_o.sum.accepted             = (st == mhpf_pkg::STATUS_OK) && acc;
    push_o.sum.final_result         = 1'b1;

    idx_d = (idx_q < mhpf_pkg::IDX_MAX) ? idx_q + 5'd1 : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      cw_q   <= '0;
      seq_q  <= '0;
      pan_q  <= '0;
      dest_q <= '0;
      src_q  <= '0;
      cbad_q <= 1'b0;
      sbad_q <= 1'b0;
    end else if (adv) begin
      if (in_last_q) begin
        idx_q  <= '0;
        cw_q   <= '0;
        seq_q  <= '0;
        pan_q  <= '0;
        dest_q <= '0;
        src_q  <= '0;
        cbad_q <= 1'b0;
        sbad_q <= 1'b0;
      end else begin
        idx_q  <= idx_d;
        cw_q   <= cw_d;
        seq_q  <= seq_d;
        pan_q  <= pan_d;
        dest_q <= dest_d;
        src_q  <= src_d;
        cbad_q <= cbad_d;
        sbad_q <= sbad_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> idx_q == '0 && !cbad_q && !sbad_q)
    else $error("frame state not cleared after last byte");

  a_payload_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.pay_vld |-> idx_q >= mhpf_pkg::HDR_SHORT && !cbad_q)
    else $error("payload item before a valid header");

  a_push_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.pay_vld || push_o.sum_vld) |-> adv)
    else $error("result pushed without an advancing item");
`endif

endmodule

>>> rtl/mhpf_queue.sv
// small result queue taking up to two results per cycle and giving one unless the output stalls
module mhpf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhpf_pkg::push_t     push_i,
  output logic                space_ok_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhpf_pkg::result_t   head_o
);

  mhpf_pkg::result_t             mem_q [mhpf_pkg::QDEPTH];
  logic [mhpf_pkg::QPTR_W-1:0]   wr_q;
  logic [mhpf_pkg::QPTR_W-1:0]   rd_q;
  logic [mhpf_pkg::QCNT_W-1:0]   cnt_q;
  logic [mhpf_pkg::QPTR_W-1:0]   sum_ptr;
  logic [mhpf_pkg::QCNT_W-1:0]   n_push;
  logic                          pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign space_ok_o  = cnt_q <= mhpf_pkg::QCNT_W'(mhpf_pkg::QDEPTH - 2);
  assign head_o      = mem_q[rd_q];
  assign sum_ptr     = wr_q + mhpf_pkg::QPTR_W'(push_i.pay_vld);
  assign n_push      = mhpf_pkg::QCNT_W'(push_i.pay_vld) +
                       mhpf_pkg::QCNT_W'(push_i.sum_vld);

  always_ff @(posedge clk_i) begin
    if (push_i.pay_vld) begin
      mem_q[wr_q] <= push_i.pay;
    end
    if (push_i.sum_vld) begin
      mem_q[sum_ptr] <= push_i.sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push[mhpf_pkg::QPTR_W-1:0];
      rd_q  <= rd_q + mhpf_pkg::QPTR_W'(pop);
      cnt_q <= cnt_q + n_push - mhpf_pkg::QCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mhpf_pkg::QCNT_W'(mhpf_pkg::QDEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push != '0 |-> space_ok_o)
    else $error("push into result queue without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != mhpf_pkg::QCNT_W'(mhpf_pkg::QDEPTH) |->
      wr_q - rd_q == cnt_q[mhpf_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");
`endif

endmodule

>>> rtl/mac_header_parse_filter_core.sv
// top level of the frame header parser and destination filter
// One frame byte is taken per item, with frame_end on the last byte. The block
// captures the little-endian frame control, sequence byte, destination PAN,
// short or extended destination and 8-byte source EUI, then emits each payload
// byte after a valid header as a kind 0 item, and on the last byte a kind 1
// summary with status, fields and the accept flag (short destination 1 or 2,
// or an extended destination equal to the local EUI). A new byte is taken every
// cycle unless input is held, as each byte needs only one pass of field capture
// logic; results go from the input register into the result queue. A last byte
// that is also payload yields two results, which the four-entry result queue,
// drained one item per cycle, absorbs without holding input; input is held only
// when results back up behind a stalled output. The user must write the own
// address via cfg_we_i / cfg_wdata_i only while idle; this is not enforced.
module mac_header_parse_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] frame_ctrl_o,
  output logic [7:0]  sequence_number_o,
  output logic [15:0] dest_pan_id_o,
  output logic        destination_extended_o,
  output logic [63:0] destination_address_o,
  output logic [63:0] source_address_o,
  output logic        accepted_o,
  output logic        final_result_o
);

  logic [63:0]       node_eui_q;
  logic              space_ok;
  mhpf_pkg::push_t   push;
  mhpf_pkg::result_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_eui_q <= '0;
    end else if (cfg_we_i) begin
      node_eui_q <= cfg_wdata_i;
    end
  end

  mhpf_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .node_eui_i  (node_eui_q),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  mhpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o                 = head.kind;
  assign payload_byte_o         = head.payload_byte;
  assign status_o               = head.status;
  assign frame_ctrl_o           = head.frame_ctrl;
  assign sequence_number_o      = head.sequence_number;
  assign dest_pan_id_o          = head.dest_pan_id;
  assign destination_extended_o = head.destination_extended;
  assign destination_address_o  = head.destination_address;
  assign source_address_o       = head.source_address;
  assign accepted_o             = head.accepted;
  assign final_result_o         = head.final_result;

endmodule
